// File: sv/hqp_pkg.sv
// ----------------------------------------------------------------------------
// hqp_pkg
// Shared types, codes and helpers of the quadratic-probe hash table.
// ----------------------------------------------------------------------------
package hqp_pkg;

  localparam int SLOT_DEPTH_DEF = 64;
  localparam int KEY_CHARS_DEF  = 8;
  localparam int VALUE_BITS_DEF = 32;

  localparam int SIZE_W      = 6;   // table size and slot index, up to 53
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = 6;
  localparam int MAXE_W      = 5;
  localparam int PRIME_COUNT = 16;
  localparam logic [MAXE_W-1:0] MAXE_RESET = 5'd26;

  localparam logic [SIZE_W-1:0] PRIMES [PRIME_COUNT] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19,
    6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53
  };

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_DELETE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_PLACE, S_LOC, S_CMP,
    S_CHAIN, S_CHK, S_CRD, S_CHASH, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    HP_IDLE, HP_LOAD, HP_RED
  } hphase_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic              clear_all;
    logic              re;
    logic [SIZE_W-1:0] raddr;
    logic              we;
    logic [SIZE_W-1:0] waddr;
    logic [KEY_W-1:0]  wkey;
    logic [VAL_W-1:0]  wval;
    logic              uset;
    logic              uclr;
    logic [SIZE_W-1:0] uaddr;
  } store_ctl_t;

  // smallest listed prime >= 2*m that fits the slot store, else the largest that fits
  function automatic logic [SIZE_W-1:0] pick_size(input logic [MAXE_W-1:0] m,
                                                  input int depth);
    logic [SIZE_W-1:0] best;
    logic              hit;
    best = PRIMES[0];
    hit  = 1'b0;
    for (int k = 0; k < PRIME_COUNT; k++) begin
      if (!hit && ({m, 1'b0} <= PRIMES[k]) && (int'(PRIMES[k]) <= depth)) begin
        best = PRIMES[k];
        hit  = 1'b1;
      end
    end
    if (!hit) begin
      for (int k = 0; k < PRIME_COUNT; k++) begin
        if (int'(PRIMES[k]) <= depth) best = PRIMES[k];
      end
    end
    return best;
  endfunction

  // (a + b) mod n for a < n, b <= n
  function automatic logic [SIZE_W-1:0] add_mod(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b,
                                                input logic [SIZE_W-1:0] n);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[SIZE_W-1:0];
  endfunction

endpackage

// File: sv/hqp_hash.sv
// ----------------------------------------------------------------------------
// hqp_hash
// Base-127 string hash mod table size, one bit of remainder per cycle.
// ----------------------------------------------------------------------------
module hqp_hash #(
  parameter int KEY_CHARS = hqp_pkg::KEY_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hqp_pkg::KEY_W-1:0]     key,
  input  logic [hqp_pkg::SIZE_W-1:0]    size,
  output logic                          done,
  output logic [hqp_pkg::SIZE_W-1:0]    hash,
  output logic [hqp_pkg::KEY_W-1:0]     nkey
);
  localparam int CW = $clog2(KEY_CHARS + 1);
  localparam int XW = 13;   // 127*52 + 255 fits

  hqp_pkg::hphase_t phase, phase_next;
  logic [hqp_pkg::KEY_W-1:0]  key_r;
  logic [CW-1:0]              c;
  logic [3:0]                 nb;
  logic [XW-1:0]              x, xl;
  logic [hqp_pkg::SIZE_W-1:0] h, r, rnx;
  logic [hqp_pkg::SIZE_W:0]   r2;
  logic [7:0]                 ch;
  logic                       last_char;

  always_comb begin
    int sel;
    sel = (int'(c) < KEY_CHARS) ? int'(c) : 0;
    ch  = key_r[8*(KEY_CHARS-1-sel) +: 8];
    last_char = (int'(c) == KEY_CHARS) || (ch == 8'd0);
    xl  = XW'(h) * XW'(127) + XW'(ch);
    r2  = {r, x[XW-1]};
    rnx = (r2 >= {1'b0, size}) ? hqp_pkg::SIZE_W'(r2 - {1'b0, size})
                               : r2[hqp_pkg::SIZE_W-1:0];
  end

  // key with everything past the first zero character cleared
  always_comb begin
    logic alive;
    alive = 1'b1;
    nkey  = '0;
    for (int k = 0; k < KEY_CHARS; k++) begin
      alive = alive && (key_r[8*(KEY_CHARS-1-k) +: 8] != 8'd0);
      nkey[8*(KEY_CHARS-1-k) +: 8] = alive ? key_r[8*(KEY_CHARS-1-k) +: 8] : 8'd0;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      hqp_pkg::HP_IDLE: if (start) phase_next = hqp_pkg::HP_LOAD;
      hqp_pkg::HP_LOAD: phase_next = last_char ? hqp_pkg::HP_IDLE : hqp_pkg::HP_RED;
      hqp_pkg::HP_RED:  if (nb == 4'd0) phase_next = hqp_pkg::HP_LOAD;
      default:          phase_next = hqp_pkg::HP_IDLE;
    endcase
  end

  always_comb begin
    done = (phase == hqp_pkg::HP_LOAD) && last_char;
    hash = h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hqp_pkg::HP_IDLE;
    end else begin
      phase <= phase_next;
    end
    case (phase)
      hqp_pkg::HP_IDLE: if (start) begin
        key_r <= key;
        c     <= '0;
        h     <= '0;
      end
      hqp_pkg::HP_LOAD: begin
        x  <= xl;
        r  <= '0;
        nb <= 4'(XW - 1);
      end
      hqp_pkg::HP_RED: begin
        r <= rnx;
        x <= x << 1;
        if (nb == 4'd0) begin
          h <= rnx;
          c <= c + 1'b1;
        end else begin
          nb <= nb - 4'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

// File: sv/hqp_store.sv
// ----------------------------------------------------------------------------
// hqp_store
// Slot memory (key and value, registered read) plus slot-used flags.
// ----------------------------------------------------------------------------
module hqp_store #(
  parameter int SLOT_DEPTH = hqp_pkg::SLOT_DEPTH_DEF,
  parameter int KEY_CHARS  = hqp_pkg::KEY_CHARS_DEF,
  parameter int VALUE_BITS = hqp_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hqp_pkg::store_ctl_t        ctl,
  output logic [SLOT_DEPTH-1:0]      used,
  output logic [hqp_pkg::KEY_W-1:0]  rkey,
  output logic [hqp_pkg::VAL_W-1:0]  rval
);
  localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int KW = 8 * KEY_CHARS;
  localparam int VW = VALUE_BITS;

  logic [KW+VW-1:0] mem [SLOT_DEPTH];
  logic [KW+VW-1:0] rd;

  always_ff @(posedge clk) begin
    if (ctl.we) mem[ctl.waddr[AW-1:0]] <= {ctl.wkey[KW-1:0], ctl.wval[VW-1:0]};
    if (ctl.re) rd <= mem[ctl.raddr[AW-1:0]];
  end

  assign rkey = hqp_pkg::KEY_W'(rd[KW+VW-1:VW]);
  assign rval = hqp_pkg::VAL_W'(rd[VW-1:0]);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      used <= '0;
    end else begin
      if (ctl.we)   used[ctl.waddr[AW-1:0]] <= 1'b1;
      if (ctl.uset) used[ctl.uaddr[AW-1:0]] <= 1'b1;
      if (ctl.uclr) used[ctl.uaddr[AW-1:0]] <= 1'b0;
    end
  end
endmodule

// File: sv/hash_table_quadratic_probe_unit.sv
// ----------------------------------------------------------------------------
// hash_table_quadratic_probe_unit
// Open-addressing string hash table, quadratic probing, insert/search/delete.
// ----------------------------------------------------------------------------
//  channel   signals                     direction  handshake
//  request   start, busy, req            in         start && !busy
//  result    done, rsp                   out        done strobe, one cycle
//  config    cfg_valid, cfg_ready,       in         cfg_valid && cfg_ready
//            cfg_data (max_entries)
//
// Steps: the hash loads each key character, then reduces the remainder
//   bit-serially; insert then probes one slot per cycle, search/delete
//   read memory then compare per probe. Delete adds per moved entry a
//   chain step, a check, a memory read, a rehash and a placement walk.
// Reset: synchronous; table empty, max_entries 26. A config write clears
//   all used flags and the entry count.
// Stalls: busy holds off requests until the cycle after the done strobe;
//   results cannot be held by the receiver.
// ----------------------------------------------------------------------------
module hash_table_quadratic_probe_unit #(
  parameter int SLOT_DEPTH = hqp_pkg::SLOT_DEPTH_DEF,
  parameter int KEY_CHARS  = hqp_pkg::KEY_CHARS_DEF,
  parameter int VALUE_BITS = hqp_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  hqp_pkg::req_t               req,
  output logic                        done,
  output hqp_pkg::rsp_t               rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hqp_pkg::MAXE_W-1:0]  cfg_data
);
  localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int KW = 8 * KEY_CHARS;
  localparam int VW = VALUE_BITS;
  localparam int SW = hqp_pkg::SIZE_W;

  hqp_pkg::state_t     state, state_next;
  hqp_pkg::store_ctl_t ctl;

  logic [SLOT_DEPTH-1:0]        used;
  logic [hqp_pkg::KEY_W-1:0]    rkey, hkey, hnkey;
  logic [hqp_pkg::VAL_W-1:0]    rval, found;
  logic [SW-1:0]                hval;
  logic                         hstart, hdone;

  logic [1:0]                   op;
  logic [1:0]                   status;
  logic [hqp_pkg::CNT_W-1:0]    count;
  logic [SW-1:0]                size;
  logic [SW-1:0]                idx, step, i;      // probe walk
  logic [SW-1:0]                cj, cstep, ci;     // delete chain walk
  logic [KW-1:0]                wkey;
  logic [VW-1:0]                wval;

  logic          cfg_wr, req_ok, used_idx, used_cj, probe_end, key_hit;
  logic [SW-1:0] step_nx, idx_nx, cstep_nx, cj_nx;

  hqp_hash #(.KEY_CHARS(KEY_CHARS)) u_hash (
    .clk(clk), .rst(rst), .start(hstart), .key(hkey), .size(size),
    .done(hdone), .hash(hval), .nkey(hnkey)
  );

  hqp_store #(.SLOT_DEPTH(SLOT_DEPTH), .KEY_CHARS(KEY_CHARS), .VALUE_BITS(VALUE_BITS))
  u_store (
    .clk(clk), .rst(rst), .ctl(ctl), .used(used), .rkey(rkey), .rval(rval)
  );

  always_comb begin
    cfg_wr    = cfg_valid && cfg_ready;
    req_ok    = (req.func == hqp_pkg::FN_INSERT) || (req.func == hqp_pkg::FN_SEARCH) ||
                (req.func == hqp_pkg::FN_DELETE);
    used_idx  = used[idx[AW-1:0]];
    used_cj   = used[cj[AW-1:0]];
    probe_end = (i == size);
    key_hit   = (rkey == hnkey);
    // offsets i+i*i advance by 2(i+1), kept mod size
    step_nx   = hqp_pkg::add_mod(step, SW'(2), size);
    idx_nx    = hqp_pkg::add_mod(idx, step_nx, size);
    cstep_nx  = hqp_pkg::add_mod(cstep, SW'(2), size);
    cj_nx     = hqp_pkg::add_mod(cj, cstep_nx, size);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hqp_pkg::S_IDLE:
        if (start) state_next = req_ok ? hqp_pkg::S_HASH : hqp_pkg::S_DONE;
      hqp_pkg::S_HASH:
        if (hdone) state_next = (op == hqp_pkg::FN_INSERT) ? hqp_pkg::S_PLACE
                                                          : hqp_pkg::S_LOC;
      hqp_pkg::S_PLACE:
        if (probe_end || !used_idx)
          state_next = (op == hqp_pkg::FN_INSERT) ? hqp_pkg::S_DONE : hqp_pkg::S_CHAIN;
      hqp_pkg::S_LOC:
        state_next = (probe_end || !used_idx) ? hqp_pkg::S_DONE : hqp_pkg::S_CMP;
      hqp_pkg::S_CMP:
        if (!key_hit)                         state_next = hqp_pkg::S_LOC;
        else if (op == hqp_pkg::FN_DELETE)    state_next = hqp_pkg::S_CHAIN;
        else                                  state_next = hqp_pkg::S_DONE;
      hqp_pkg::S_CHAIN:
        state_next = (ci == size) ? hqp_pkg::S_DONE : hqp_pkg::S_CHK;
      hqp_pkg::S_CHK:
        state_next = used_cj ? hqp_pkg::S_CRD : hqp_pkg::S_DONE;
      hqp_pkg::S_CRD:   state_next = hqp_pkg::S_CHASH;
      hqp_pkg::S_CHASH: if (hdone) state_next = hqp_pkg::S_PLACE;
      hqp_pkg::S_DONE:  state_next = hqp_pkg::S_IDLE;
      default:          state_next = hqp_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = (state != hqp_pkg::S_IDLE);
    cfg_ready = (state == hqp_pkg::S_IDLE);
    done      = (state == hqp_pkg::S_DONE);
    hstart    = ((state == hqp_pkg::S_IDLE) && start && req_ok) ||
                (state == hqp_pkg::S_CRD);
    hkey      = (state == hqp_pkg::S_CRD) ? rkey : req.key;
    ctl       = '0;
    ctl.clear_all = cfg_wr;
    ctl.wkey  = hqp_pkg::KEY_W'(wkey);
    ctl.wval  = hqp_pkg::VAL_W'(wval);
    ctl.waddr = idx;
    case (state)
      hqp_pkg::S_LOC: begin
        ctl.re    = !probe_end && used_idx;
        ctl.raddr = idx;
      end
      hqp_pkg::S_CMP: begin
        ctl.uclr  = key_hit && (op == hqp_pkg::FN_DELETE);
        ctl.uaddr = idx;
      end
      hqp_pkg::S_CHK: begin
        ctl.re    = used_cj;
        ctl.raddr = cj;
      end
      hqp_pkg::S_CRD: begin
        // free the slot so the reinsertion may land on it
        ctl.uclr  = 1'b1;
        ctl.uaddr = cj;
      end
      hqp_pkg::S_PLACE: begin
        ctl.we    = !probe_end && !used_idx;
        // no room: the moved entry stays where it was
        ctl.uset  = probe_end && (op == hqp_pkg::FN_DELETE);
        ctl.uaddr = cj;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hqp_pkg::S_IDLE;
      size  <= hqp_pkg::pick_size(hqp_pkg::MAXE_RESET, SLOT_DEPTH);
      count <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        size  <= hqp_pkg::pick_size(cfg_data, SLOT_DEPTH);
        count <= '0;
      end
      if ((state == hqp_pkg::S_PLACE) && !probe_end && !used_idx &&
          (op == hqp_pkg::FN_INSERT))
        count <= count + 1'b1;
      if ((state == hqp_pkg::S_CMP) && key_hit && (op == hqp_pkg::FN_DELETE))
        count <= count - 1'b1;
    end

    case (state)
      hqp_pkg::S_IDLE: if (start) begin
        op     <= req.func;
        wval   <= req.value[VW-1:0];
        status <= hqp_pkg::ST_OK;
        found  <= '0;
      end
      hqp_pkg::S_HASH: if (hdone) begin
        idx  <= hval;
        step <= '0;
        i    <= '0;
        wkey <= hnkey[KW-1:0];
      end
      hqp_pkg::S_PLACE: begin
        if (probe_end) begin
          if (op == hqp_pkg::FN_INSERT) status <= hqp_pkg::ST_FULL;
        end else if (used_idx) begin
          idx  <= idx_nx;
          step <= step_nx;
          i    <= i + 1'b1;
        end
      end
      hqp_pkg::S_LOC:
        if (probe_end || !used_idx) status <= hqp_pkg::ST_NOTFOUND;
      hqp_pkg::S_CMP: begin
        if (key_hit) begin
          if (op == hqp_pkg::FN_SEARCH) found <= rval;
          cj    <= idx;
          cstep <= '0;
          ci    <= SW'(1);
        end else begin
          idx  <= idx_nx;
          step <= step_nx;
          i    <= i + 1'b1;
        end
      end
      hqp_pkg::S_CHAIN: if (ci != size) begin
        cj    <= cj_nx;
        cstep <= cstep_nx;
        ci    <= ci + 1'b1;
      end
      hqp_pkg::S_CRD: begin
        wkey <= rkey[KW-1:0];
        wval <= rval[VW-1:0];
      end
      hqp_pkg::S_CHASH: if (hdone) begin
        idx  <= hval;
        step <= '0;
        i    <= '0;
      end
      default: ;
    endcase
  end

  assign rsp.status      = status;
  assign rsp.found_value = found;
  assign rsp.entry_count = count;

  // occupancy never exceeds the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= hqp_pkg::CNT_W'(size))
    else $error("entry count above table size");

  // a placement leaves its slot occupied
  a_place_used: assert property (@(posedge clk) disable iff (rst)
    ctl.we |=> used[$past(ctl.waddr[AW-1:0])])
    else $error("placed slot not marked used");

  // memory reads only touch occupied slots
  a_read_used: assert property (@(posedge clk) disable iff (rst)
    ctl.re |-> used[ctl.raddr[AW-1:0]])
    else $error("read of an empty slot");

  // a result strobe closes a busy period
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("still busy after result");
endmodule

// File: verif/tb_hash_table_quadratic_probe_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hash_table_quadratic_probe_unit
// Self-checking bench for the quadratic-probe hash table. A table predictor
// tracks slots and count, is fed every accepted request and queues the
// response it implies; each done strobe is checked against the oldest one.
// Directed corner requests come first, then random phases over a range of
// max_entries settings, with keys mostly drawn from a small pool per phase.
// ----------------------------------------------------------------------------
module tb_hash_table_quadratic_probe_unit;

  localparam logic [1:0] FN_NOP   = 2'd3;  // unused opcode, must be ignored
  localparam int         DEPTH    = 64;
  localparam int         POOL_MAX = 12;
  localparam int         TAIL     = 300;   // drain cycles after the last response

  // --------------------------------------------------------------------------
  // Table predictor and response store
  // --------------------------------------------------------------------------
  class table_scoreboard;
    bit                         used [DEPTH];
    logic [hqp_pkg::KEY_W-1:0]  keys [DEPTH];
    logic [hqp_pkg::VAL_W-1:0]  vals [DEPTH];
    int                         count;
    int                         size;
    hqp_pkg::rsp_t              pending [$];
    int                         errors;

    // smallest prime from the list that is >= 2*m; 27..31 fall back to 53
    function void set_max(logic [hqp_pkg::MAXE_W-1:0] m);
      int plist [16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};
      size = 53;
      for (int k = 15; k >= 0; k--)
        if (2 * int'(m) <= plist[k]) size = plist[k];
      foreach (used[i]) used[i] = 1'b0;
      count = 0;
    endfunction

    // key cut at the first zero byte, plus its hash
    function logic [hqp_pkg::KEY_W-1:0] trim_key(logic [hqp_pkg::KEY_W-1:0] k,
                                                 output int h);
      logic [hqp_pkg::KEY_W-1:0] kept;
      int ch;
      kept = '0;
      h = 0;
      for (int c = 0; c < 8; c++) begin
        ch = k[63-8*c -: 8];
        if (ch == 0) break;
        kept[63-8*c -: 8] = ch[7:0];
        h = (127 * h + ch) % size;
      end
      return kept;
    endfunction

    function int slot_at(int s, int i);
      return (s + i + i * i) % size;
    endfunction

    function int put(logic [hqp_pkg::KEY_W-1:0] k, int h, logic [hqp_pkg::VAL_W-1:0] v);
      int idx;
      for (int i = 0; i < size; i++) begin
        idx = slot_at(h, i);
        if (!used[idx]) begin
          used[idx] = 1'b1;
          keys[idx] = k;
          vals[idx] = v;
          count++;
          return idx;
        end
      end
      return -1;
    endfunction

    function int find(logic [hqp_pkg::KEY_W-1:0] k, int h);
      int idx;
      for (int i = 0; i < size; i++) begin
        idx = slot_at(h, i);
        if (!used[idx]) return -1;
        if (keys[idx] == k) return idx;
      end
      return -1;
    endfunction

    // apply one request and queue the response it should produce
    function void note_request(hqp_pkg::req_t r);
      hqp_pkg::rsp_t             e;
      int                        h, pos, j, rh;
      logic [hqp_pkg::KEY_W-1:0] nk, mk;
      logic [hqp_pkg::VAL_W-1:0] mv;
      e = '0;
      nk = trim_key(r.key, h);
      case (r.func)
        hqp_pkg::FN_INSERT: begin
          if (put(nk, h, r.value) < 0) e.status = hqp_pkg::ST_FULL;
        end
        hqp_pkg::FN_SEARCH: begin
          pos = find(nk, h);
          if (pos < 0) e.status = hqp_pkg::ST_NOTFOUND;
          else e.found_value = vals[pos];
        end
        hqp_pkg::FN_DELETE: begin
          pos = find(nk, h);
          if (pos < 0) begin
            e.status = hqp_pkg::ST_NOTFOUND;
          end else begin
            used[pos] = 1'b0;
            count--;
            // pull the chain that follows and place each entry again
            for (int i = 1; i < size; i++) begin
              j = slot_at(pos, i);
              if (!used[j]) break;
              mk = keys[j];
              mv = vals[j];
              used[j] = 1'b0;
              count--;
              void'(trim_key(mk, rh));
              if (put(mk, rh, mv) < 0) begin
                used[j] = 1'b1;
                count++;
              end
            end
          end
        end
        default: ;
      endcase
      e.entry_count = count[hqp_pkg::CNT_W-1:0];
      pending.push_back(e);
    endfunction

    function void check_response(hqp_pkg::rsp_t got);
      hqp_pkg::rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response, actual %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.found_value !== e.found_value) begin
        $display("%0t: found_value expected %h actual %h", $time,
                 e.found_value, got.found_value);
        errors++;
      end
      if (got.entry_count !== e.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time,
                 e.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clock
  // --------------------------------------------------------------------------
  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  hqp_pkg::req_t                 req;
  logic                          done;
  hqp_pkg::rsp_t                 rsp;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [hqp_pkg::MAXE_W-1:0]    cfg_data;

  table_scoreboard               sb;
  logic [hqp_pkg::KEY_W-1:0]     pool [POOL_MAX];
  int                            pool_n;
  bit                            no_gaps;

  hash_table_quadratic_probe_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // responses are one-cycle strobes; sample at the rising edge
  always @(posedge clk) begin
    if (!rst && done) sb.check_response(rsp);
  end

  // --------------------------------------------------------------------------
  // Drivers: called at a falling edge, return at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_request(logic [1:0] fn, logic [hqp_pkg::KEY_W-1:0] k,
                              logic [hqp_pkg::VAL_W-1:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    req.func  = fn;
    req.key   = k;
    req.value = v;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    @(negedge clk);
  endtask

  // config only when idle: all responses in, then a short quiet stretch
  task automatic write_max(logic [hqp_pkg::MAXE_W-1:0] m);
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = m;
    do @(posedge clk); while (!cfg_ready);
    sb.set_max(m);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random key of 0..8 chars; bytes past the terminator are junk
  function automatic logic [hqp_pkg::KEY_W-1:0] random_key();
    logic [hqp_pkg::KEY_W-1:0] k;
    int n;
    k = {$urandom, $urandom};
    n = $urandom_range(0, 8);
    for (int c = 0; c < 8; c++) begin
      if (c < n) k[63-8*c -: 8] = 8'($urandom_range(1, 255));
      else if (c == n) k[63-8*c -: 8] = 8'h00;
    end
    return k;
  endfunction

  // pool key with fresh junk after its terminator
  function automatic logic [hqp_pkg::KEY_W-1:0] pool_key();
    logic [hqp_pkg::KEY_W-1:0] k, junk;
    bit cut;
    k = pool[$urandom_range(0, pool_n - 1)];
    junk = {$urandom, $urandom};
    cut = 1'b0;
    for (int c = 0; c < 8; c++) begin
      if (cut) k[63-8*c -: 8] = junk[63-8*c -: 8];
      if (k[63-8*c -: 8] == 8'h00) cut = 1'b1;
    end
    return k;
  endfunction

  task automatic random_phase(logic [hqp_pkg::MAXE_W-1:0] m, int n_items);
    int sel;
    logic [1:0] fn;
    write_max(m);
    no_gaps = ($urandom_range(0, 2) == 0);
    pool_n = $urandom_range(2, POOL_MAX);
    for (int i = 0; i < pool_n; i++) pool[i] = random_key();
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) fn = hqp_pkg::FN_INSERT;
      else if (sel < 72) fn = hqp_pkg::FN_SEARCH;
      else if (sel < 95) fn = hqp_pkg::FN_DELETE;
      else fn = FN_NOP;
      send_request(fn, ($urandom_range(0, 9) < 8) ? pool_key() : random_key(), $urandom);
    end
    no_gaps = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [hqp_pkg::MAXE_W-1:0] settings [8];
    logic [hqp_pkg::KEY_W-1:0]  kA, kF, kJ;
    int wait_n;
    settings  = '{5'd31, 5'd3, 5'd7, 5'd12, 5'd20, 5'd0, 5'd26, 5'd5};
    sb = new();
    sb.set_max(hqp_pkg::MAXE_RESET);
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset size 53
    kA = {8'h41, 56'h0};
    kF = '1;
    kJ = 64'h4142_0012_3456_789A;           // "AB" with junk after the zero
    send_request(hqp_pkg::FN_INSERT, 64'h0, 32'h0000_0000);      // empty key
    send_request(hqp_pkg::FN_SEARCH, 64'h00FF_FFFF_FFFF_FFFF, 32'h0);
    send_request(hqp_pkg::FN_INSERT, kA, 32'hFFFF_FFFF);
    send_request(hqp_pkg::FN_INSERT, kF, 32'h1234_5678);
    send_request(hqp_pkg::FN_INSERT, kJ, 32'hA5A5_5A5A);
    send_request(hqp_pkg::FN_SEARCH, 64'h4142_00FF_0000_0000, 32'hFFFF_FFFF);
    send_request(hqp_pkg::FN_INSERT, kA, 32'h0000_0001);         // duplicate key
    send_request(hqp_pkg::FN_DELETE, kA, 32'h0);
    send_request(hqp_pkg::FN_SEARCH, kA, 32'h0);
    send_request(hqp_pkg::FN_DELETE, 64'h5A00_0000_0000_0000, 32'h0);  // missing
    send_request(FN_NOP, kF, 32'hDEAD_BEEF);
    send_request(hqp_pkg::FN_SEARCH, kF, 32'h0);
    send_request(hqp_pkg::FN_DELETE, 64'h0, 32'h0);

    // directed: smallest table, overflow and chain repair
    write_max(5'd1);
    send_request(hqp_pkg::FN_INSERT, kA, 32'h1);
    send_request(hqp_pkg::FN_INSERT, kF, 32'h2);
    send_request(hqp_pkg::FN_INSERT, kJ, 32'h3);                 // table full
    send_request(hqp_pkg::FN_DELETE, kA, 32'h0);
    send_request(hqp_pkg::FN_SEARCH, kF, 32'h0);
    write_max(5'd0);
    send_request(hqp_pkg::FN_INSERT, 64'h0, 32'h7);
    send_request(hqp_pkg::FN_SEARCH, 64'h0, 32'h0);

    // random phases over several sizes, extremes included
    foreach (settings[p]) random_phase(settings[p], 80);

    // drain, then give any trailing activity time to show up
    start = 1'b0;
    wait_n = 0;
    while (sb.pending.size() != 0 && wait_n < 200000) begin
      @(negedge clk);
      wait_n++;
    end
    repeat (TAIL) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_hash_table_quadratic_probe_unit: PASS");
    end else begin
      $display("tb_hash_table_quadratic_probe_unit: FAIL");
    end
    $finish;
  end

  // watchdog: far above the slowest legal run
  initial begin
    #200ms;
    $display("tb_hash_table_quadratic_probe_unit: FAIL");
    $finish;
  end

endmodule
